// ----- hw/rtl/rfg_pkg.sv -----
// ----------------------------------------------------------------------------
// rfg_pkg
// Shared types and constants for the fraction reduction block.
// ----------------------------------------------------------------------------
`default_nettype none

package rfg_pkg;

    // default operand width
    localparam int RFG_DATA_WIDTH = 31;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_TWOS,
        S_REDUCE,
        S_SCALE,
        S_DIV_NUM,
        S_DIV_DEN,
        S_DONE
    } t_state;

    // top level to core
    typedef struct packed {
        logic start;
        logic take;
    } t_ctl;

    // core to top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/reduce_fraction_by_gcd.sv -----
// Sequence: a word with a zero operand goes straight to done; any other word passes
// through binary gcd steps, power-of-two scaling and two DATA_WIDTH-step divisions,
// then into the output register.
// Throughput: one word at a time; the gcd subtract steps and the division steps share
// one subtractor, and the next word is taken once the current one has left the core.
// Reset: synchronous, active low; sequencer returns to idle, output empty.
`default_nettype none

// ----------------------------------------------------------------------------
// reduce_fraction_by_gcd
// Reduces a fraction to lowest terms and returns the gcd; zero operands are
// flagged and passed through.
// ----------------------------------------------------------------------------
module reduce_fraction_by_gcd #(
    parameter int DATA_WIDTH = rfg_pkg::RFG_DATA_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [DATA_WIDTH-1:0] i_numerator_in,
    input  wire logic [DATA_WIDTH-1:0] i_denominator_in,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [DATA_WIDTH-1:0] o_numerator_out,
    output logic      [DATA_WIDTH-1:0] o_denominator_out,
    output logic      [DATA_WIDTH-1:0] o_common_divisor,
    output logic                       o_zero_error
);
    import rfg_pkg::*;

    t_ctl                  ctl;
    t_sts                  sts;
    logic [DATA_WIDTH-1:0] core_num, core_den, core_gcd;
    logic                  core_err;
    logic                  r_vld, n_vld;
    logic [DATA_WIDTH-1:0] r_num, r_den, r_gcd;
    logic                  r_err;

    // word handoff between core and output register
    assign ctl.start = i_valid && sts.idle;
    assign ctl.take  = sts.done && (!r_vld || !i_stall);
    assign o_stall   = !sts.idle;

    rfg_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .i_num   (i_numerator_in),
        .i_den   (i_denominator_in),
        .o_num   (core_num),
        .o_den   (core_den),
        .o_gcd   (core_gcd),
        .o_err   (core_err)
    );

    // output valid
    always_comb begin
        n_vld = r_vld;
        if (ctl.take) begin
            n_vld = 1'b1;
        end else if (!i_stall) begin
            n_vld = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (ctl.take) begin
            r_num <= core_num;
            r_den <= core_den;
            r_gcd <= core_gcd;
            r_err <= core_err;
        end
    end

    assign o_valid           = r_vld;
    assign o_numerator_out   = r_num;
    assign o_denominator_out = r_den;
    assign o_common_divisor  = r_gcd;
    assign o_zero_error      = r_err;

endmodule

`default_nettype wire

// ----- hw/rtl/rfg_sub.sv -----
// ----------------------------------------------------------------------------
// rfg_sub
// Shared subtract and compare unit, used by both the gcd and the divider steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rfg_sub #(
    parameter int DATA_WIDTH = rfg_pkg::RFG_DATA_WIDTH
) (
    input  wire logic [DATA_WIDTH:0] i_x,
    input  wire logic [DATA_WIDTH:0] i_y,
    output logic      [DATA_WIDTH:0] o_diff,
    output logic                     o_borrow
);

    // x - y with borrow out, borrow set when x < y
    assign {o_borrow, o_diff} = {1'b0, i_x} - {1'b0, i_y};

endmodule

`default_nettype wire

// ----- hw/rtl/rfg_core.sv -----
// ----------------------------------------------------------------------------
// rfg_core
// Sequencer: binary gcd, scale by common powers of two, then two restoring
// divisions by the gcd; the gcd and the divisions share one subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module rfg_core #(
    parameter int DATA_WIDTH = rfg_pkg::RFG_DATA_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire rfg_pkg::t_ctl           i_ctl,
    output rfg_pkg::t_sts                o_sts,
    input  wire logic [DATA_WIDTH-1:0]   i_num,
    input  wire logic [DATA_WIDTH-1:0]   i_den,
    output logic      [DATA_WIDTH-1:0]   o_num,
    output logic      [DATA_WIDTH-1:0]   o_den,
    output logic      [DATA_WIDTH-1:0]   o_gcd,
    output logic                         o_err
);
    import rfg_pkg::*;

    localparam int KW = $clog2(DATA_WIDTH + 1);
    localparam logic [KW-1:0] LAST_STEP = KW'(DATA_WIDTH - 1);

    t_state                r_state, n_state;
    logic [DATA_WIDTH-1:0] r_a, n_a;
    logic [DATA_WIDTH-1:0] r_b, n_b;
    logic [DATA_WIDTH-1:0] r_g, n_g;
    logic [DATA_WIDTH-1:0] r_num, n_num;
    logic [DATA_WIDTH-1:0] r_den, n_den;
    logic                  r_err, n_err;
    logic [KW-1:0]         r_k, n_k;
    logic [KW-1:0]         r_cnt, n_cnt;

    logic [DATA_WIDTH:0]   sub_x, sub_y, sub_diff;
    logic                  sub_borrow;
    logic [DATA_WIDTH-1:0] q_next;
    logic [DATA_WIDTH-1:0] rem_next;

    // operand select for the shared subtractor
    always_comb begin
        if (r_state == S_REDUCE) begin
            sub_x = {1'b0, r_a};
            sub_y = {1'b0, r_b};
        end else begin
            sub_x = {r_b, r_a[DATA_WIDTH-1]};
            sub_y = {1'b0, r_g};
        end
    end

    rfg_sub #(.DATA_WIDTH(DATA_WIDTH)) u_sub (
        .i_x      (sub_x),
        .i_y      (sub_y),
        .o_diff   (sub_diff),
        .o_borrow (sub_borrow)
    );

    // one restoring division step: shift in dividend bit, trial subtract
    assign q_next   = {r_a[DATA_WIDTH-2:0], ~sub_borrow};
    assign rem_next = sub_borrow ? sub_x[DATA_WIDTH-1:0] : sub_diff[DATA_WIDTH-1:0];

    // state register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_g   <= n_g;
        r_num <= n_num;
        r_den <= n_den;
        r_err <= n_err;
        r_k   <= n_k;
        r_cnt <= n_cnt;
    end

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_g     = r_g;
        n_num   = r_num;
        n_den   = r_den;
        n_err   = r_err;
        n_k     = r_k;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_num = i_num;
                    n_den = i_den;
                    n_a   = i_num;
                    n_b   = i_den;
                    n_k   = '0;
                    n_g   = '0;
                    if (i_num == '0 || i_den == '0) begin
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_err   = 1'b0;
                        n_state = S_TWOS;
                    end
                end
            end
            // strip common factors of two
            S_TWOS: begin
                if (r_a[0] || r_b[0]) begin
                    n_state = S_REDUCE;
                end else begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + 1'b1;
                end
            end
            // binary gcd on the odd part, one shift, swap or subtract a cycle
            S_REDUCE: begin
                if (r_a == '0) begin
                    n_state = S_SCALE;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (sub_borrow) begin
                    n_a = r_b;
                    n_b = r_a;
                end else begin
                    n_a = sub_diff[DATA_WIDTH-1:0];
                end
            end
            // restore the powers of two, then set up the first division
            S_SCALE: begin
                if (r_k == '0) begin
                    n_g     = r_b;
                    n_a     = r_num;
                    n_b     = '0;
                    n_cnt   = '0;
                    n_state = S_DIV_NUM;
                end else begin
                    n_b = r_b << 1;
                    n_k = r_k - 1'b1;
                end
            end
            S_DIV_NUM: begin
                n_a   = q_next;
                n_b   = rem_next;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_num   = q_next;
                    n_a     = r_den;
                    n_b     = '0;
                    n_cnt   = '0;
                    n_state = S_DIV_DEN;
                end
            end
            S_DIV_DEN: begin
                n_a   = q_next;
                n_b   = rem_next;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_den   = q_next;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = (r_state == S_DONE);
    assign o_num      = r_num;
    assign o_den      = r_den;
    assign o_gcd      = r_g;
    assign o_err      = r_err;

endmodule

`default_nettype wire

// ----- hw/rtl/rfg_checker.sv -----
// ----------------------------------------------------------------------------
// rfg_checker
// Port-level checks on the fraction reduction block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rfg_checker #(
    parameter int DATA_WIDTH = rfg_pkg::RFG_DATA_WIDTH
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_valid,
    input wire logic                  o_stall,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic [DATA_WIDTH-1:0] o_numerator_out,
    input wire logic [DATA_WIDTH-1:0] o_denominator_out,
    input wire logic [DATA_WIDTH-1:0] o_common_divisor,
    input wire logic                  o_zero_error
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_numerator_out)
            && $stable(o_denominator_out) && $stable(o_common_divisor)
            && $stable(o_zero_error))
        else $error("stalled output word changed");

    // output empties on reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a taken input word makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after accepting a word");

    // error word carries a zero divisor
    a_err_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_error |-> o_common_divisor == '0)
        else $error("zero error with nonzero divisor");

    // reduced fraction has nonzero parts
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_zero_error |-> o_common_divisor != '0
            && o_numerator_out != '0 && o_denominator_out != '0)
        else $error("zero value in reduced fraction");

endmodule

bind reduce_fraction_by_gcd rfg_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rfg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_numerator_out   (o_numerator_out),
    .o_denominator_out (o_denominator_out),
    .o_common_divisor  (o_common_divisor),
    .o_zero_error      (o_zero_error)
);

`default_nettype wire

// ----- test/reduce_fraction_by_gcd_tb.sv -----
// ----------------------------------------------------------------------------
// reduce_fraction_by_gcd_tb
// Sends numerator/denominator words into the fraction reducer and checks each
// returned word against a Euclid-based prediction of the reduced fraction,
// the gcd and the zero flag, with random idling and back-pressure on both
// channels, two long output hold-offs and one full drain in mid-run.
// ----------------------------------------------------------------------------
module reduce_fraction_by_gcd_tb;
    import rfg_pkg::*;

    localparam int W = RFG_DATA_WIDTH;

    typedef logic [W-1:0] value_t;

    localparam value_t MAX_VAL = '1;

    // one reduced fraction as the block should return it
    typedef struct {
        value_t num;
        value_t den;
        value_t gcd;
        logic   zero_err;
    } fraction_t;

    // predicted fractions, oldest first, and the checks against them
    class fraction_scoreboard;
        fraction_t expected_q[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function value_t euclid_divisor(value_t a, value_t b);
            value_t r;
            while (b != '0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        // predict the reduced fraction for an accepted input word
        function void note_input(value_t n, value_t d);
            fraction_t f;
            value_t    g;
            if (n == '0 || d == '0) begin
                f = '{num: n, den: d, gcd: '0, zero_err: 1'b1};
            end else begin
                g = euclid_divisor(n, d);
                f = '{num: n / g, den: d / g, gcd: g, zero_err: 1'b0};
            end
            expected_q.push_back(f);
        endfunction

        function void compare_field(string name, value_t exp_v, value_t act_v);
            if (exp_v !== act_v) begin
                $display("%0t: mismatch on %s: expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare an accepted result word with the oldest prediction
        function void check_result(value_t n, value_t d, value_t g, logic z);
            fraction_t f;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %0d/%0d gcd %0d err %0b",
                         $time, n, d, g, z);
                errors++;
                return;
            end
            f = expected_q.pop_front();
            compare_field("numerator", f.num, n);
            compare_field("denominator", f.den, d);
            compare_field("gcd", f.gcd, g);
            compare_field("zero flag", value_t'(f.zero_err), value_t'(z));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    value_t i_numerator_in;
    value_t i_denominator_in;
    logic   o_valid;
    logic   i_stall;
    value_t o_numerator_out;
    value_t o_denominator_out;
    value_t o_common_divisor;
    logic   o_zero_error;

    fraction_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit long_hold_req;

    reduce_fraction_by_gcd dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_numerator_in    (i_numerator_in),
        .i_denominator_in  (i_denominator_in),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_numerator_out   (o_numerator_out),
        .o_denominator_out (o_denominator_out),
        .o_common_divisor  (o_common_divisor),
        .o_zero_error      (o_zero_error)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #30000000;
        $display("simulation failed");
        $finish;
    end

    // random value of w low bits
    function automatic value_t rand_width(int w);
        return value_t'($urandom) & (MAX_VAL >> (W - w));
    endfunction

    // offer one word after random idle cycles, wait until it is taken
    task automatic send_word(input value_t n, input value_t d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid          <= 1'b0;
            i_numerator_in   <= value_t'($urandom);
            i_denominator_in <= value_t'($urandom);
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_numerator_in   <= n;
        i_denominator_in <= d;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        sb.note_input(n, d);
    endtask

    // random word, mostly shaped to hit real common factors
    task automatic send_random_word();
        int     kind;
        int     wg;
        value_t g;
        value_t a;
        value_t b;
        value_t n;
        value_t d;
        kind = $urandom_range(99);
        if (kind < 6) begin
            // zero operand on one or both sides
            case ($urandom_range(2))
                0:       begin n = '0; d = rand_width($urandom_range(W, 1)); end
                1:       begin n = rand_width($urandom_range(W, 1)); d = '0; end
                default: begin n = '0; d = '0; end
            endcase
        end else if (kind < 45) begin
            // built from a common factor, products fit in W bits
            wg = $urandom_range(W - 1, 1);
            g  = rand_width(wg);
            if (g == '0) g = value_t'(1);
            a  = rand_width($urandom_range(W - wg, 1));
            b  = rand_width($urandom_range(W - wg, 1));
            if (a == '0) a = value_t'(1);
            if (b == '0) b = value_t'(1);
            n = a * g;
            d = b * g;
        end else if (kind < 55) begin
            // many trailing zeros
            n = rand_width($urandom_range(8, 1)) << $urandom_range(W - 1, 0);
            d = rand_width($urandom_range(8, 1)) << $urandom_range(W - 1, 0);
        end else if (kind < 65) begin
            n = rand_width(8);
            d = rand_width(8);
        end else if (kind < 70) begin
            // equal values or a unit side
            n = rand_width($urandom_range(W, 1));
            d = $urandom_range(1) ? n : value_t'(1);
        end else begin
            n = rand_width(W);
            d = rand_width(W);
        end
        send_word(n, d);
    endtask

    // wait for every predicted word, with a cap
    task automatic wait_drained();
        int cycles;
        cycles = 0;
        while (sb.pending() != 0 && cycles < 100000) begin
            @(posedge i_clk);
            cycles++;
        end
    endtask

    // directed corners: extremes, zeros, coprime, powers of two
    task automatic send_directed();
        send_word(MAX_VAL, MAX_VAL);
        send_word(MAX_VAL, value_t'(1));
        send_word(value_t'(1), MAX_VAL);
        send_word(value_t'(1), value_t'(1));
        send_word('0, '0);
        send_word('0, value_t'(5));
        send_word(value_t'(7), '0);
        send_word('0, MAX_VAL);
        send_word(MAX_VAL, '0);
        send_word(value_t'(12), value_t'(18));
        send_word(value_t'(6), value_t'(4));
        send_word(value_t'(1) << (W - 1), value_t'(1) << (W - 2));
        send_word(value_t'(1) << (W - 1), value_t'(3));
        send_word(MAX_VAL, MAX_VAL - value_t'(1));
        send_word(MAX_VAL, value_t'(1) << (W - 1));
        send_word(value_t'(123456), value_t'(123456));
        send_word(value_t'(3) << 15, value_t'(9) << 20);
        send_word(value_t'(32'h5555_5555), value_t'(32'h2aaa_aaaa));
        send_word(value_t'(65537 * 17), value_t'(65537 * 255));
        send_word(value_t'(1) << (W - 1), value_t'(1) << (W - 1));
        send_word(value_t'(2), MAX_VAL);
    endtask

    // receiver: check taken words, random stall, long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
                sb.check_result(o_numerator_out, o_denominator_out,
                                o_common_divisor, o_zero_error);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = 600;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // main sequence
    initial begin
        sb            = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 1'b0;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_numerator_in   <= '0;
        i_denominator_in <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles a little, receiver a lot
        send_idle_pct = 18;
        recv_idle_pct = 69;
        send_directed();
        for (int i = 0; i < 460; i++) begin
            if (i == 200) long_hold_req = 1'b1;
            send_random_word();
        end

        // receiver idles a little, sender a lot; sender pauses for a drain
        send_idle_pct = 69;
        recv_idle_pct = 18;
        for (int i = 0; i < 460; i++) begin
            if (i == 230) begin
                i_valid <= 1'b0;
                wait_drained();
            end
            send_random_word();
        end

        // no idling, one long hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 460; i++) begin
            if (i == 150) long_hold_req = 1'b1;
            send_random_word();
        end
        i_valid <= 1'b0;

        wait_drained();
        repeat (400) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: missing result words: expected %0d more, actual 0",
                     $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
